/* rtl/sjf_pkg.sv */
// Package for the shortest-job-first scheduler: widths, payload types, sweep token, states.
package sjf_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int TIME_W       = 16;
  localparam int SLOT_OUT_W   = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0]     current_time;
    logic                  running_valid;
    logic [SLOT_OUT_W-1:0] running_slot;
    logic                  started;
    logic [TIME_W-1:0]     response_time;
    logic                  finished;
    logic [SLOT_OUT_W-1:0] finished_slot;
    logic [TIME_W-1:0]     completion_time;
    logic [TIME_W-1:0]     turnaround_time;
    logic [TIME_W-1:0]     waiting_time;
    logic                  all_done;
  } res_t;

  // Token passed cell to cell during a sweep (slot numbers travel beside it)
  typedef struct packed {
    logic [TIME_W-1:0] cur_arr;
    logic [TIME_W-1:0] cur_burst;
    logic [TIME_W-1:0] cur_rem;
    logic              any_pend;
    logic              arr_found;
    logic [TIME_W-1:0] arr_rem;
    logic [TIME_W-1:0] arr_arr;
    logic              arr_started;
    logic              earl_found;
    logic [TIME_W-1:0] earl;
    logic [TIME_W-1:0] earl_rem;
    logic              earl_started;
  } sweep_t;

  // Broadcast commands from the controller to the cells
  typedef struct packed {
    logic              load;
    logic              dec;
    logic              mark;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_LAUNCH,
    ST_SWEEP,
    ST_DONE
  } state_e;

endpackage

/* rtl/sjf_stream_if.sv */
// Valid/ready stream interface carrying one payload struct.
interface sjf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/sjf_nonpreemptive_scheduler_core.sv */
// Top level of the non-preemptive shortest-job-first scheduler: controller and cell chain.
//
// Each request transfer yields exactly one result transfer. On a load the job is written
// into the next free cell, if the table is not full, and the result is registered at once.
// A tick steps through the controller states: DEC advances the time and takes a unit
// from the running job, LAUNCH launches the search token, SWEEP lets the token walk the
// chain cell by cell and collect the shortest arrived job and the earliest pending
// arrival, and DONE resolves completion and dispatch. Requests are
// taken again once the controller is idle and the result register is free or draining.
module sjf_nonpreemptive_scheduler_core import sjf_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sjf_stream_if.sink    req_i,
  sjf_stream_if.source  res_o
);

  localparam int SLOT_W = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  job_cnt_q;
  logic [TIME_W-1:0] time_q;
  logic [SLOT_W-1:0] cur_slot_q;
  logic              busy_q;
  logic              all_done_q;
  logic              out_vld_q;
  res_t              res_q, res_d;

  logic              in_ready, acc, acc_load, acc_tick, not_full;
  logic              res_set;
  cell_ctrl_t        ctrl;
  logic [SLOT_W-1:0] ctrl_slot;

  // chain wiring
  logic              tok_vld  [MAX_JOBS+1];
  sweep_t            tok      [MAX_JOBS+1];
  logic [SLOT_W-1:0] arr_slot [MAX_JOBS+1];
  logic [SLOT_W-1:0] earl_slot[MAX_JOBS+1];
  sweep_t            tok_end;

  // resolve step
  logic              fin, busy_left, disp, start;
  logic [TIME_W-1:0] tat, wt, time_n, resp, sel_arr;
  logic [SLOT_W-1:0] sel_slot;
  logic              sel_started;

  assign not_full = (job_cnt_q < CNT_W'(MAX_JOBS));
  assign acc      = req_i.valid && in_ready;
  assign acc_load = acc && (req_i.payload.req_type == REQ_LOAD);
  assign acc_tick = acc && (req_i.payload.req_type == REQ_TICK);
  assign tok_end  = tok[MAX_JOBS];

  // Requests only while idle with the result register free or draining
  assign in_ready = (state_q == ST_IDLE) && (!out_vld_q || res_o.ready);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (acc_tick) state_d = ST_DEC;
      ST_DEC:    state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_SWEEP;
      ST_SWEEP:  if (tok_vld[MAX_JOBS]) state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    ctrl.load    = 1'b0;
    ctrl.dec     = 1'b0;
    ctrl.mark    = 1'b0;
    ctrl.arrival = req_i.payload.arrival_time;
    ctrl.burst   = req_i.payload.burst_time;
    ctrl_slot    = cur_slot_q;
    tok_vld[0]   = 1'b0;
    res_set      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ctrl.load = acc_load && not_full;
        if (acc_load) ctrl_slot = job_cnt_q[SLOT_W-1:0];
        res_set   = acc_load;
      end
      ST_DEC:    ctrl.dec = busy_q;
      ST_LAUNCH: tok_vld[0] = 1'b1;
      ST_SWEEP:  ;
      ST_DONE: begin
        ctrl.mark = start;
        ctrl_slot = sel_slot;
        res_set   = 1'b1;
      end
      default: ;
    endcase
  end

  assign req_i.ready = in_ready;

  // Empty token entering the chain
  always_comb begin
    tok[0]       = '0;
    tok[0].earl  = TIME_MAX;
    arr_slot[0]  = '0;
    earl_slot[0] = '0;
  end

  // Cell chain
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    sjf_cell #(
      .MAX_JOBS (MAX_JOBS),
      .IDX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .ctrl_slot_i (ctrl_slot),
      .job_cnt_i   (job_cnt_q),
      .time_i      (time_q),
      .tok_vld_i   (tok_vld[i]),
      .tok_i       (tok[i]),
      .arr_slot_i  (arr_slot[i]),
      .earl_slot_i (earl_slot[i]),
      .tok_vld_o   (tok_vld[i+1]),
      .tok_o       (tok[i+1]),
      .arr_slot_o  (arr_slot[i+1]),
      .earl_slot_o (earl_slot[i+1])
    );
  end

  // Completion and dispatch from the collected token
  always_comb begin
    fin       = busy_q && (tok_end.cur_rem == '0);
    tat       = time_q - tok_end.cur_arr;
    wt        = (tat >= tok_end.cur_burst) ? (tat - tok_end.cur_burst) : '0;
    busy_left = busy_q && !fin;
    disp      = !busy_left && tok_end.any_pend &&
                (tok_end.arr_found || tok_end.earl_found);
    if (tok_end.arr_found) begin
      sel_slot    = arr_slot[MAX_JOBS];
      sel_arr     = tok_end.arr_arr;
      sel_started = tok_end.arr_started;
      time_n      = time_q;
    end else begin
      sel_slot    = earl_slot[MAX_JOBS];
      sel_arr     = tok_end.earl;
      sel_started = tok_end.earl_started;
      // idle processor jumps to the earliest pending arrival
      time_n      = (disp && tok_end.earl > time_q) ? tok_end.earl : time_q;
    end
    start = disp && !sel_started;
    resp  = time_n - sel_arr;
  end

  // Result assembly
  always_comb begin
    res_d = '0;
    if (state_q == ST_DONE) begin
      res_d.current_time    = time_n;
      res_d.running_valid   = busy_left || disp;
      res_d.running_slot    = disp ? SLOT_OUT_W'(sel_slot) :
                              (busy_left ? SLOT_OUT_W'(cur_slot_q) : '0);
      res_d.started         = start;
      res_d.response_time   = start ? resp : '0;
      res_d.finished        = fin;
      res_d.finished_slot   = fin ? SLOT_OUT_W'(cur_slot_q) : '0;
      res_d.completion_time = fin ? time_q : '0;
      res_d.turnaround_time = fin ? tat : '0;
      res_d.waiting_time    = fin ? wt : '0;
      res_d.all_done        = !tok_end.any_pend;
    end else begin
      res_d.current_time  = time_q;
      res_d.running_valid = busy_q;
      res_d.running_slot  = busy_q ? SLOT_OUT_W'(cur_slot_q) : '0;
      res_d.all_done      = not_full ? (all_done_q && req_i.payload.burst_time == '0)
                                     : all_done_q;
    end
  end

  // Scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_cnt_q  <= '0;
      time_q     <= '0;
      cur_slot_q <= '0;
      busy_q     <= 1'b0;
      all_done_q <= 1'b1;
    end else begin
      if (ctrl.load) begin
        job_cnt_q <= job_cnt_q + 1'b1;
      end
      if (state_q == ST_DEC && time_q != TIME_MAX) begin
        time_q <= time_q + 1'b1;
      end
      if (state_q == ST_DONE) begin
        time_q <= time_n;
        busy_q <= busy_left || disp;
        if (disp) cur_slot_q <= sel_slot;
      end
      if (res_set) begin
        all_done_q <= res_d.all_done;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_set) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_set) res_q <= res_d;
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = res_q;

  // Checks
  a_token_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_vld[MAX_JOBS] |-> state_q == ST_SWEEP)
    else $error("sweep token left the chain outside a sweep");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_cnt_q <= CNT_W'(MAX_JOBS))
    else $error("job count beyond table size");

  a_busy_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> CNT_W'(cur_slot_q) < job_cnt_q)
    else $error("running slot not loaded");

  a_done_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !tok_end.any_pend) |-> !start && !busy_left)
    else $error("dispatch with nothing left");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!out_vld_q || res_o.ready))
    else $error("tick result would overwrite a pending result");

endmodule

/* rtl/sjf_cell.sv */
// One job slot of the scheduler chain: holds the job and folds it into the passing token.
module sjf_cell import sjf_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF,
  parameter int IDX      = 0,
  localparam int SLOT_W  = $clog2(MAX_JOBS),
  localparam int CNT_W   = $clog2(MAX_JOBS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [SLOT_W-1:0] ctrl_slot_i,
  input  logic [CNT_W-1:0]  job_cnt_i,
  input  logic [TIME_W-1:0] time_i,
  input  logic              tok_vld_i,
  input  sweep_t            tok_i,
  input  logic [SLOT_W-1:0] arr_slot_i,
  input  logic [SLOT_W-1:0] earl_slot_i,
  output logic              tok_vld_o,
  output sweep_t            tok_o,
  output logic [SLOT_W-1:0] arr_slot_o,
  output logic [SLOT_W-1:0] earl_slot_o
);

  logic [TIME_W-1:0] arr_q, burst_q, rem_q;
  logic              started_q;
  logic              hit, loaded, pend;
  sweep_t            tok_d;
  logic [SLOT_W-1:0] arr_slot_d, earl_slot_d;
  logic              tok_vld_q;
  sweep_t            tok_q;
  logic [SLOT_W-1:0] arr_slot_q, earl_slot_q;

  assign hit    = (ctrl_slot_i == SLOT_W'(IDX));
  assign loaded = (CNT_W'(IDX) < job_cnt_i);
  assign pend   = loaded && (rem_q != '0);

  // Job entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && hit) begin
      arr_q   <= ctrl_i.arrival;
      burst_q <= ctrl_i.burst;
      rem_q   <= ctrl_i.burst;
    end else if (ctrl_i.dec && hit && rem_q != '0) begin
      rem_q <= rem_q - 1'b1;
    end
  end

  // First-dispatch flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (ctrl_i.load && hit) begin
      started_q <= 1'b0;
    end else if (ctrl_i.mark && hit) begin
      started_q <= 1'b1;
    end
  end

  // Fold this slot into the token
  always_comb begin
    tok_d       = tok_i;
    arr_slot_d  = arr_slot_i;
    earl_slot_d = earl_slot_i;
    if (hit) begin
      tok_d.cur_arr   = arr_q;
      tok_d.cur_burst = burst_q;
      tok_d.cur_rem   = rem_q;
    end
    if (pend) begin
      tok_d.any_pend = 1'b1;
      // least remaining among arrived jobs, lower slot wins ties
      if (arr_q <= time_i && (!tok_i.arr_found || rem_q < tok_i.arr_rem)) begin
        tok_d.arr_found   = 1'b1;
        tok_d.arr_rem     = rem_q;
        tok_d.arr_arr     = arr_q;
        tok_d.arr_started = started_q;
        arr_slot_d        = SLOT_W'(IDX);
      end
      // least remaining among jobs at the earliest pending arrival
      if (!tok_i.earl_found || arr_q < tok_i.earl ||
          (arr_q == tok_i.earl && rem_q < tok_i.earl_rem)) begin
        tok_d.earl_found   = 1'b1;
        tok_d.earl         = arr_q;
        tok_d.earl_rem     = rem_q;
        tok_d.earl_started = started_q;
        earl_slot_d        = SLOT_W'(IDX);
      end
    end
  end

  // Token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q       <= tok_d;
    arr_slot_q  <= arr_slot_d;
    earl_slot_q <= earl_slot_d;
  end

  assign tok_vld_o   = tok_vld_q;
  assign tok_o       = tok_q;
  assign arr_slot_o  = arr_slot_q;
  assign earl_slot_o = earl_slot_q;

endmodule

/* sim/tb_sjf_nonpreemptive_scheduler_core.sv */
// Testbench for the shortest-job-first scheduler core: directed and random requests, scoreboard.
module tb_sjf_nonpreemptive_scheduler_core;
  import sjf_pkg::*;

  localparam int          SLOTS        = MAX_JOBS_DEF;
  localparam int          TICK_CYCLES  = SLOTS + 3;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_START   = 1500;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int          RANDOM_ITEMS = 380;
  localparam int          FILL_SLOTS   = SLOTS - 2;

  // Scheduler state mirror and queue of the reports still to arrive
  class sched_scoreboard;
    bit [TIME_W-1:0] arr_tbl[SLOTS];
    bit [TIME_W-1:0] burst_tbl[SLOTS];
    bit [TIME_W-1:0] rem_tbl[SLOTS];
    bit              started_tbl[SLOTS];
    int unsigned     job_cnt;
    bit [TIME_W-1:0] now;
    int unsigned     run_slot;
    bit              busy;
    res_t            report_q[$];
    int unsigned     mismatches;

    function new();
      foreach (arr_tbl[i]) begin
        arr_tbl[i]     = '0;
        burst_tbl[i]   = '0;
        rem_tbl[i]     = '0;
        started_tbl[i] = 1'b0;
      end
      job_cnt    = 0;
      now        = '0;
      run_slot   = 0;
      busy       = 1'b0;
      mismatches = 0;
    endfunction

    function bit none_left();
      for (int i = 0; i < job_cnt; i++)
        if (rem_tbl[i] != 0) return 1'b0;
      return 1'b1;
    endfunction

    // Arrived, unfinished job with least remaining burst; lower slot wins ties
    function int unsigned shortest_arrived();
      int unsigned best;
      int unsigned best_rem;
      best     = SLOTS;
      best_rem = 32'h10000;
      for (int i = 0; i < job_cnt; i++)
        if (rem_tbl[i] != 0 && arr_tbl[i] <= now && rem_tbl[i] < best_rem) begin
          best_rem = rem_tbl[i];
          best     = i;
        end
      return best;
    endfunction

    function int unsigned earliest_arrival();
      int unsigned t;
      t = 32'h10000;
      for (int i = 0; i < job_cnt; i++)
        if (rem_tbl[i] != 0 && arr_tbl[i] < t) t = arr_tbl[i];
      return t;
    endfunction

    // One request applied to the mirror; returns the report it causes
    function res_t advance_schedule(req_t r);
      res_t            o;
      int unsigned     s;
      int unsigned     t;
      bit [TIME_W-1:0] tat;
      o = '0;
      if (r.req_type == REQ_LOAD) begin
        if (job_cnt < SLOTS) begin
          arr_tbl[job_cnt]     = r.arrival_time;
          burst_tbl[job_cnt]   = r.burst_time;
          rem_tbl[job_cnt]     = r.burst_time;
          started_tbl[job_cnt] = 1'b0;
          job_cnt++;
        end
      end else begin
        if (now != TIME_MAX) now++;
        if (busy) begin
          s = run_slot;
          if (rem_tbl[s] != 0) rem_tbl[s]--;
          if (rem_tbl[s] == 0) begin
            tat               = now - arr_tbl[s];
            o.finished        = 1'b1;
            o.finished_slot   = s[SLOT_OUT_W-1:0];
            o.completion_time = now;
            o.turnaround_time = tat;
            // saturated time can leave turnaround below the burst
            o.waiting_time    = (tat >= burst_tbl[s]) ? tat - burst_tbl[s] : '0;
            busy              = 1'b0;
          end
        end
        if (!busy && !none_left()) begin
          s = shortest_arrived();
          if (s >= SLOTS) begin
            // idle: jump forward to the earliest pending arrival
            t = earliest_arrival();
            if (t <= TIME_MAX && t > now) now = t[TIME_W-1:0];
            s = shortest_arrived();
          end
          if (s < SLOTS) begin
            busy     = 1'b1;
            run_slot = s;
            if (!started_tbl[s]) begin
              started_tbl[s]  = 1'b1;
              o.started       = 1'b1;
              o.response_time = now - arr_tbl[s];
            end
          end
        end
      end
      o.current_time  = now;
      o.running_valid = busy;
      o.running_slot  = busy ? run_slot[SLOT_OUT_W-1:0] : '0;
      o.all_done      = none_left();
      return o;
    endfunction

    function void note_request(req_t r);
      report_q.push_back(advance_schedule(r));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (report_q.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
        return;
      end
      want = report_q.pop_front();
      compare_field("current_time", want.current_time, got.current_time);
      compare_field("running_valid", want.running_valid, got.running_valid);
      compare_field("running_slot", want.running_slot, got.running_slot);
      compare_field("started", want.started, got.started);
      compare_field("response_time", want.response_time, got.response_time);
      compare_field("finished", want.finished, got.finished);
      compare_field("finished_slot", want.finished_slot, got.finished_slot);
      compare_field("completion_time", want.completion_time, got.completion_time);
      compare_field("turnaround_time", want.turnaround_time, got.turnaround_time);
      compare_field("waiting_time", want.waiting_time, got.waiting_time);
      compare_field("all_done", want.all_done, got.all_done);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sjf_stream_if #(.payload_t(req_t)) req_if ();
  sjf_stream_if #(.payload_t(res_t)) res_if ();

  sched_scoreboard sched = new();

  int unsigned burst_left;
  int unsigned cycle_count;

  sjf_nonpreemptive_scheduler_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sched.check_report(res_if.payload);
  end

  // Run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: segments of steady, patchy and sparse ready, plus one long hold-off
  initial begin : result_sink
    int unsigned rx_cycle;
    int unsigned seg_left;
    int unsigned seg_mode;
    rx_cycle = 0;
    seg_left = 0;
    seg_mode = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 120);
        seg_mode = $urandom_range(0, 2);
      end
      seg_left--;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        res_if.ready <= 1'b0;
      end else begin
        case (seg_mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One request transfer; the sender may idle between bursts of random length
  task automatic send_request(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.payload <= r;
    req_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    sched.note_request(r);
  endtask

  task automatic do_load(input int unsigned arr, input int unsigned burst);
    req_t r;
    r.req_type     = REQ_LOAD;
    r.arrival_time = arr[TIME_W-1:0];
    r.burst_time   = burst[TIME_W-1:0];
    send_request(r);
  endtask

  // Tick with junk in the unused fields
  task automatic do_tick();
    req_t r;
    r.req_type     = REQ_TICK;
    r.arrival_time = TIME_W'($urandom_range(0, 16'hFFFF));
    r.burst_time   = TIME_W'($urandom_range(0, 16'hFFFF));
    send_request(r);
  endtask

  // Job arriving in the past, soon, or far enough ahead to force a time jump
  task automatic load_random_job();
    int unsigned arr;
    int unsigned burst;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3)      arr = $urandom_range(0, sched.now);
    else if (pick < 9) arr = sched.now + $urandom_range(0, 40);
    else               arr = sched.now + $urandom_range(100, 3000);
    burst = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
    do_load(arr, burst);
  endtask

  initial begin : stimulus
    req_t junk;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    burst_left     = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, then a job that is already done
    do_tick();
    do_load(0, 0);
    do_tick();
    // Equal bursts: lower slot goes first
    do_load(0, 2);
    do_load(0, 2);
    repeat (6) do_tick();
    // Idle with only a future arrival: time jumps
    do_load(sched.now + 50, 1);
    do_tick();
    do_tick();
    // A later, shorter job must not preempt the running one
    do_load(0, 4);
    do_load(sched.now + 2, 1);
    repeat (6) do_tick();

    // Random mix, mostly ticks
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (sched.job_cnt < FILL_SLOTS && $urandom_range(0, 19) == 0) load_random_job();
      else do_tick();
    end
    while (sched.job_cnt < FILL_SLOTS) load_random_job();

    // Saturation: the late job completes at the time ceiling, then the longest one starts
    do_load(TIME_MAX - 5, 20);
    do_load(TIME_MAX, TIME_MAX);
    while (!sched.started_tbl[SLOTS-1]) do_tick();

    // Table full: loads are ignored
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        junk.req_type     = REQ_LOAD;
        junk.arrival_time = TIME_W'($urandom_range(0, 16'hFFFF));
        junk.burst_time   = TIME_W'($urandom_range(0, 16'hFFFF));
        send_request(junk);
      end else begin
        do_tick();
      end
    end
    req_if.valid <= 1'b0;

    // Drain, then allow for stray results
    while (sched.report_q.size() != 0) @(posedge clk_i);
    repeat (2 * TICK_CYCLES) @(posedge clk_i);
    if (sched.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sjf_pkg.sv
rtl/sjf_stream_if.sv
rtl/sjf_cell.sv
rtl/sjf_nonpreemptive_scheduler_core.sv
sim/tb_sjf_nonpreemptive_scheduler_core.sv
